// File: hw/rtl/htfd_pkg.sv
// ---------------------------------------------------------------------------
// htfd_pkg
// shared types and constants of the humidity/temperature frame decoder
// ---------------------------------------------------------------------------
package htfd_pkg;

    // crc-8, msb first, no final xor
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // byte positions within a frame
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TEMP_CRC = 2'd1;
    localparam logic [1:0] ST_HUM_CRC  = 2'd2;

    // conversion constants
    localparam logic [14:0] T_SPAN     = 15'd17500;
    localparam logic [13:0] H_SPAN     = 14'd12500;
    localparam logic [30:0] ROUND_HALF = 31'd32767;
    localparam logic [14:0] T_OFFSET   = 15'd4500;
    localparam logic [13:0] H_OFFSET   = 14'd600;
    localparam logic [13:0] H_TOP      = 14'd10600;
    localparam logic [13:0] H_MAX      = 14'd10000;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic        temp_good;
        logic        hum_good;
        logic [15:0] raw_t;
        logic [15:0] raw_h;
    } t_frame_rec;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_FIN
    } t_bk_state;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/htfd_front.sv
// ---------------------------------------------------------------------------
// htfd_front
// byte position tracking, crc checking and word assembly
// ---------------------------------------------------------------------------
module htfd_front
    import htfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic       i_q_ready,
    output logic       o_push,
    output t_frame_rec o_rec
);

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_hum, n_hum;
    logic        r_tgood, n_tgood;
    logic        w_accept;
    logic [2:0]  w_pos;
    logic [7:0]  w_crc;
    logic        w_resync;

    assign o_ready  = i_q_ready;
    assign w_accept = i_valid && i_q_ready;
    assign w_resync = i_start || (r_pos > POS_H_CRC);
    assign w_pos    = w_resync ? POS_T_HI : r_pos;
    assign w_crc    = w_resync ? CRC_INIT : r_crc;

    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_temp  = r_temp;
        n_hum   = r_hum;
        n_tgood = r_tgood;
        o_push  = 1'b0;
        o_rec   = '{temp_good: r_tgood, hum_good: (w_crc == i_byte),
                    raw_t: r_temp, raw_h: r_hum};
        if (w_accept) begin
            n_pos = (w_pos == POS_H_CRC) ? POS_T_HI : w_pos + 3'd1;
            unique case (w_pos)
                POS_T_HI: begin
                    n_temp = {i_byte, r_temp[7:0]};
                    n_crc  = crc8_byte(w_crc, i_byte);
                end
                POS_T_LO: begin
                    n_temp = {r_temp[15:8], i_byte};
                    n_crc  = crc8_byte(w_crc, i_byte);
                end
                POS_T_CRC: begin
                    n_tgood = (w_crc == i_byte);
                    n_crc   = CRC_INIT;
                end
                POS_H_HI: begin
                    n_hum = {i_byte, r_hum[7:0]};
                    n_crc = crc8_byte(w_crc, i_byte);
                end
                POS_H_LO: begin
                    n_hum = {r_hum[15:8], i_byte};
                    n_crc = crc8_byte(w_crc, i_byte);
                end
                POS_H_CRC: begin
                    n_crc  = CRC_INIT;
                    o_push = 1'b1;
                end
                default: begin
                    n_crc = CRC_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_T_HI;
            r_crc   <= CRC_INIT;
            r_tgood <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_tgood <= n_tgood;
        end
    end

    always_ff @(posedge i_clk) begin
        r_temp <= n_temp;
        r_hum  <= n_hum;
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_H_CRC)
        else $error("byte position out of frame");
`endif

endmodule

// File: hw/rtl/htfd_queue.sv
// ---------------------------------------------------------------------------
// htfd_queue
// short queue of checked frames between front and back
// ---------------------------------------------------------------------------
module htfd_queue
    import htfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_ready,
    input  t_frame_rec i_rec,
    output logic       o_valid,
    input  logic       i_pop,
    output t_frame_rec o_rec
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame_rec       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("frame pushed into full queue");
`endif

endmodule

// File: hw/rtl/htfd_back.sv
// ---------------------------------------------------------------------------
// htfd_back
// scaling of raw words to hundredths and result register
// ---------------------------------------------------------------------------
module htfd_back
    import htfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_pop,
    input  t_frame_rec  i_rec,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [14:0] o_temp_centi,
    output logic [13:0] o_hum_centi,
    output logic [15:0] o_raw_t,
    output logic [15:0] o_raw_h
);

    t_bk_state   r_state, n_state;
    t_frame_rec  r_rec;
    logic [30:0] r_prod_t, r_prod_h;
    logic [14:0] r_tq;
    logic [13:0] r_hq;
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [14:0] r_temp_centi;
    logic [13:0] r_hum_centi;
    logic [15:0] r_raw_t, r_raw_h;
    logic [31:0] w_sum_t, w_sum_h;
    logic        w_load;
    logic [13:0] w_hum;

    // x / 65535 as (x + (x >> 16) + 1) >> 16, exact for quotients below 2^16
    assign w_sum_t = {1'b0, r_prod_t} + 32'(r_prod_t[30:16]) + 32'd1;
    assign w_sum_h = {1'b0, r_prod_h} + 32'(r_prod_h[30:16]) + 32'd1;

    always_comb begin
        if (r_hq < H_OFFSET) begin
            w_hum = '0;
        end else if (r_hq > H_TOP) begin
            w_hum = H_MAX;
        end else begin
            w_hum = r_hq - H_OFFSET;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_state = BK_MUL;
                end
            end
            BK_MUL: n_state = BK_DIV;
            BK_DIV: n_state = BK_FIN;
            BK_FIN: begin
                if (!r_out_valid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
        if (r_state == BK_MUL) begin
            r_prod_t <= 31'(T_SPAN) * 31'(r_rec.raw_t) + ROUND_HALF;
            r_prod_h <= 31'(H_SPAN) * 31'(r_rec.raw_h) + ROUND_HALF;
        end
        if (r_state == BK_DIV) begin
            r_tq <= w_sum_t[30:16];
            r_hq <= w_sum_h[29:16];
        end
        if (w_load) begin
            priority if (!r_rec.temp_good) begin
                r_status     <= ST_TEMP_CRC;
                r_temp_centi <= '0;
                r_hum_centi  <= '0;
            end else if (!r_rec.hum_good) begin
                r_status     <= ST_HUM_CRC;
                r_temp_centi <= '0;
                r_hum_centi  <= '0;
            end else begin
                r_status     <= ST_OK;
                r_temp_centi <= r_tq - T_OFFSET;
                r_hum_centi  <= w_hum;
            end
            r_raw_t <= r_rec.raw_t;
            r_raw_h <= r_rec.raw_h;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_temp_centi = r_temp_centi;
    assign o_hum_centi  = r_hum_centi;
    assign o_raw_t      = r_raw_t;
    assign o_raw_h      = r_raw_h;

`ifndef SYNTHESIS
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status == ST_OK || r_status == ST_TEMP_CRC
                         || r_status == ST_HUM_CRC))
        else $error("undefined status code on result");
    a_hum_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_hum_centi <= H_MAX))
        else $error("humidity beyond clamp");
`endif

endmodule

// File: hw/rtl/humidity_temp_frame_decoder_top.sv
// ---------------------------------------------------------------------------
// humidity_temp_frame_decoder_top
// decodes six-byte humidity/temperature sensor frames into checked results
// ---------------------------------------------------------------------------
// usage
//   slave channel: one frame byte per transaction, in order temp hi, temp lo,
//   temp crc, rh hi, rh lo, rh crc; tuser marks the first byte of a frame and
//   drops any partial frame. without it the byte count wraps after six bytes
//   master channel: one result transaction per frame on its sixth byte, with
//   status, temperature and humidity in hundredths and the two raw words
// throughput
//   one byte per cycle while the queue has room; the front checks crc on
//   the fly and a two-entry frame queue decouples it from the back
// result path
//   after the sixth byte's transaction the frame is written to the queue,
//   then queue read, multiply, reciprocal divide and result register in the back
// stall
//   the back holds a finished result in its output register while the
//   receiver stalls; bytes keep flowing until the queue fills, then tready
//   drops. reset clears byte count, crc, queue and result valid
// ---------------------------------------------------------------------------
module humidity_temp_frame_decoder_top
    import htfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  i_s_axis_tuser,   // [0] frame_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata    // [1:0] status, [16:2] temperature_centi,
                                          // [30:17] humidity_centi, [46:31] raw_temperature,
                                          // [62:47] raw_humidity, [63] zero
);

    // front to queue
    logic       w_push;
    logic       w_q_ready;
    t_frame_rec w_push_rec;

    // queue to back
    logic       w_q_valid;
    logic       w_pop;
    t_frame_rec w_pop_rec;

    // result fields
    logic [1:0]  w_status;
    logic [14:0] w_temp_centi;
    logic [13:0] w_hum_centi;
    logic [15:0] w_raw_t;
    logic [15:0] w_raw_h;

    htfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata),
        .i_start   (i_s_axis_tuser[0]),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_rec     (w_push_rec)
    );

    htfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_q_ready),
        .i_rec   (w_push_rec),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_rec   (w_pop_rec)
    );

    htfd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .o_pop        (w_pop),
        .i_rec        (w_pop_rec),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_status     (w_status),
        .o_temp_centi (w_temp_centi),
        .o_hum_centi  (w_hum_centi),
        .o_raw_t      (w_raw_t),
        .o_raw_h      (w_raw_h)
    );

    // pack result fields, lowest field first, padded to whole bytes
    assign o_m_axis_tdata = {1'b0, w_raw_h, w_raw_t, w_hum_centi, w_temp_centi, w_status};

endmodule

// File: sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the humidity/temperature frame decoder: a short
// stimulus table of zero, full-scale, crc error and resync frames, then
// random frames mixed with noise and truncated frames; each result is
// checked against its table row or a cycle-free decoder kept in the bench
// ---------------------------------------------------------------------------
module tb_top;
    import htfd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 600;
    localparam int DIRECTED_LEN = 26;
    localparam int DRAIN_CYCLES = 20;

    // one decoded frame as it leaves the master channel
    typedef struct packed {
        logic [1:0]         status;
        logic signed [14:0] temp_centi;
        logic [13:0]        hum_centi;
        logic [15:0]        raw_t;
        logic [15:0]        raw_h;
    } t_frame_result;

    // crc_row: data is an xor mask on the correct crc instead of the byte itself
    typedef struct packed {
        logic [7:0]    data;
        logic          sof;
        logic          crc_row;
        logic          has_exp;
        t_frame_result res;
    } t_stim_row;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_TRICKLE,
        RX_MOSTLY
    } t_rx_mode;

    localparam t_frame_result NO_RES = '0;

    localparam t_stim_row DIRECTED [DIRECTED_LEN] = '{
        // zero words straight after reset: coldest reading, humidity clamped to zero
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, 1'b1, '{ST_OK, -15'sd4500, 14'd0, 16'h0000, 16'h0000}},
        // all-ones words with no start flag, so the byte count has to wrap;
        // hottest reading, humidity clamped at full scale
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, 1'b1, '{ST_OK, 15'sd13000, 14'd10000, 16'hFFFF, 16'hFFFF}},
        // partial frame, dropped by the start flag on the next row
        '{8'h77, 1'b1, 1'b0, 1'b0, NO_RES},
        '{8'h88, 1'b0, 1'b0, 1'b0, NO_RES},
        // both crcs wrong: the temperature error takes precedence
        '{8'h12, 1'b1, 1'b0, 1'b0, NO_RES},
        '{8'h34, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'h56, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h78, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h80, 1'b0, 1'b1, 1'b1, '{ST_TEMP_CRC, 15'sd0, 14'd0, 16'h1234, 16'h5678}},
        // humidity crc wrong only
        '{8'hBE, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hEF, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
        '{8'h66, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h66, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b1, 1'b1, '{ST_HUM_CRC, 15'sd0, 14'd0, 16'hBEEF, 16'h6666}}
    };

    // dut ports, inputs at known values from time zero
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic [0:0]  i_s_axis_tuser  = 1'b0;    // [0] frame_start
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;            // [1:0] status, [16:2] temperature_centi,
                                            // [30:17] humidity_centi, [46:31] raw_temperature,
                                            // [62:47] raw_humidity, [63] zero

    // bench copy of the decoder state
    logic [2:0]  frame_pos;
    logic [7:0]  crc_run;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        temp_crc_ok;

    t_frame_result pending_frames [$];
    int          fails          = 0;
    int          cycles         = 0;
    int          bytes_accepted = 0;
    int          burst_left     = 0;
    int          stall_tick     = 0;
    t_rx_mode    stall_mode     = RX_OPEN;

    humidity_temp_frame_decoder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // crc-8 one bit at a time, msb first
    function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] r;
        logic       fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ d[i];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // advance the bench decoder by one byte; got is set on the sixth byte
    task automatic decode_frame_byte(input logic [7:0] b, input logic sof,
                                     output logic got, output t_frame_result res);
        logic [2:0]  p;
        logic        hum_ok;
        int unsigned tq;
        int unsigned hq;
        got = 1'b0;
        res = '0;
        p   = frame_pos;
        if (sof || p > POS_H_CRC) begin
            p       = POS_T_HI;
            crc_run = CRC_INIT;
        end
        case (p)
            POS_T_HI: begin
                temp_word[15:8] = b;
                crc_run         = crc_step(crc_run, b);
            end
            POS_T_LO: begin
                temp_word[7:0] = b;
                crc_run        = crc_step(crc_run, b);
            end
            POS_T_CRC: begin
                temp_crc_ok = (crc_run == b);
                crc_run     = CRC_INIT;
            end
            POS_H_HI: begin
                hum_word[15:8] = b;
                crc_run        = crc_step(crc_run, b);
            end
            POS_H_LO: begin
                hum_word[7:0] = b;
                crc_run       = crc_step(crc_run, b);
            end
            default: begin
                hum_ok    = (crc_run == b);
                crc_run   = CRC_INIT;
                got       = 1'b1;
                res.raw_t = temp_word;
                res.raw_h = hum_word;
                if (!temp_crc_ok) begin
                    res.status = ST_TEMP_CRC;
                end else if (!hum_ok) begin
                    res.status = ST_HUM_CRC;
                end else begin
                    // round to nearest hundredth; 65535 is odd so no ties
                    res.status     = ST_OK;
                    tq             = (32'd17500 * temp_word + 32'd32767) / 32'd65535;
                    hq             = (32'd12500 * hum_word + 32'd32767) / 32'd65535;
                    res.temp_centi = 15'(tq - 32'd4500);
                    if (hq < 600)
                        res.hum_centi = 14'd0;
                    else if (hq - 600 > 10000)
                        res.hum_centi = 14'd10000;
                    else
                        res.hum_centi = 14'(hq - 600);
                end
            end
        endcase
        frame_pos = (p == POS_H_CRC) ? POS_T_HI : p + 3'd1;
    endtask

    // one byte transaction on the slave channel, with burst gaps in front
    task automatic push_byte(input logic [7:0] d, input logic sof, input logic crc_row,
                             input logic has_exp, input t_frame_result typed);
        logic [7:0]    b;
        logic          got;
        t_frame_result res;
        int            gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                @(negedge i_clk) i_s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        // crc rows carry the correct crc, xored with the row's mask
        b = crc_row ? d ^ ((sof || frame_pos > POS_H_CRC) ? CRC_INIT : crc_run) : d;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= sof;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        bytes_accepted++;
        decode_frame_byte(b, sof, got, res);
        if (got)
            pending_frames.push_back(has_exp ? typed : res);
    endtask

    // raw word biased towards the extremes and both clamp regions
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 3300));
            3:       return 16'($urandom_range(55000, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    // a frame with random words; crcs mostly right, len below six cuts it short
    task automatic send_frame(input logic sof, input int len);
        logic [15:0] tw;
        logic [15:0] hw;
        logic [7:0]  t_mask;
        logic [7:0]  h_mask;
        logic [7:0]  bytes [6];
        logic        is_crc [6];
        tw     = pick_word();
        hw     = pick_word();
        t_mask = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        h_mask = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        bytes  = '{tw[15:8], tw[7:0], t_mask, hw[15:8], hw[7:0], h_mask};
        is_crc = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
        for (int i = 0; i < len; i++)
            push_byte(bytes[i], (i == 0) ? sof : 1'b0, is_crc[i], 1'b0, NO_RES);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // receiver: tready driven by a stall pattern that is redrawn at random
    always @(negedge i_clk) begin
        if (stall_tick % 50 == 0)
            stall_mode = t_rx_mode'($urandom_range(0, 3));
        case (stall_mode)
            RX_OPEN:    i_m_axis_tready <= 1'b1;
            RX_COIN:    i_m_axis_tready <= 1'($urandom_range(0, 1));
            RX_TRICKLE: i_m_axis_tready <= (stall_tick % 8 == 0);
            default:    i_m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
        stall_tick++;
    end

    // result transactions against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_frames.size() == 0) begin
                $error("result transaction with none expected, tdata %h", o_m_axis_tdata);
                fails++;
            end else begin
                want = pending_frames.pop_front();
                check_field("status", want.status, o_m_axis_tdata[1:0]);
                check_field("temperature_centi", want.temp_centi,
                            $signed(o_m_axis_tdata[16:2]));
                check_field("humidity_centi", want.hum_centi, o_m_axis_tdata[30:17]);
                check_field("raw_temperature", want.raw_t, o_m_axis_tdata[46:31]);
                check_field("raw_humidity", want.raw_h, o_m_axis_tdata[62:47]);
                check_field("pad", 0, o_m_axis_tdata[63]);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        frame_pos   = POS_T_HI;
        crc_run     = CRC_INIT;
        temp_word   = 16'h0000;
        hum_word    = 16'h0000;
        temp_crc_ok = 1'b0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_LEN; i++)
            push_byte(DIRECTED[i].data, DIRECTED[i].sof, DIRECTED[i].crc_row,
                      DIRECTED[i].has_exp, DIRECTED[i].res);

        // mostly clean frames, some noise and truncated frames
        while (bytes_accepted < DIRECTED_LEN + RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                8: begin
                    repeat ($urandom_range(1, 5))
                        push_byte(8'($urandom), ($urandom_range(0, 3) == 0), 1'b0, 1'b0,
                                  NO_RES);
                end
                9:       send_frame(1'b1, $urandom_range(1, 5));
                default: send_frame((frame_pos != POS_T_HI) || 1'($urandom_range(0, 1)), 6);
            endcase
        end
        @(negedge i_clk) i_s_axis_tvalid <= 1'b0;

        // drain, then allow for the pipeline latency
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/htfd_pkg.sv
hw/rtl/htfd_front.sv
hw/rtl/htfd_queue.sv
hw/rtl/htfd_back.sv
hw/rtl/humidity_temp_frame_decoder_top.sv
sim/tb_top.sv
